// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/dlf_pkg.sv =====
// ----------------------------------------------------------------------------
// Dense layer package
// Sizes, formats, state codes, command and status structs, and the exp table.
// ----------------------------------------------------------------------------
package dlf_pkg;

	localparam int MAX_NEURONS   = 32;
	localparam int MAX_INPUTS    = 64;
	localparam int EXP_DEPTH     = 256;
	localparam int NEU_W         = $clog2(MAX_NEURONS);
	localparam int IN_W          = $clog2(MAX_INPUTS);
	localparam int WADDR_W       = NEU_W + IN_W;
	localparam int NCNT_W        = 6;
	localparam int ICNT_W        = 7;
	localparam int VAL_W         = 16;
	localparam int PROD_W        = 2 * VAL_W;
	localparam int SUM_W         = 32;
	localparam int ACC_W         = PROD_W + IN_W;
	localparam int ACT_W         = 16;
	localparam int EXP_W         = 17;
	localparam int EXP_IDX_W     = $clog2(EXP_DEPTH);
	localparam int EXP_IDX_SHIFT = 11;
	localparam int DIFF_W        = SUM_W + 1;
	localparam int DIV_W         = EXP_W + ACT_W;
	localparam int DIV_CNT_W     = $clog2(DIV_W);
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 7;
	localparam logic [63:0] EXP_STEP = 64'd4162825043;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEURONS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INPUTS  = 2'd2;

	localparam logic OP_WEIGHT = 1'b0;
	localparam logic OP_INPUT  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC,
		ST_MAC_DRAIN,
		ST_MAX,
		ST_MAX_WAIT,
		ST_EXP,
		ST_EXP_WAIT,
		ST_OUT_RD,
		ST_OUT_LOAD,
		ST_OUT_DIV,
		ST_EMIT
	} dlf_state_t;

	typedef struct packed {
		logic             w_we;
		logic             x_we;
		logic             mac_v;
		logic             mac_first;
		logic             mac_last;
		logic [NEU_W-1:0] row;
		logic [IN_W-1:0]  col;
		logic             pass_first;
		logic             max_upd;
		logic             exp_acc;
		logic             out_load;
		logic             div_step;
		logic             emit;
		logic             last_neuron;
		logic             softmax;
	} dlf_cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} dlf_status_t;

	typedef logic [EXP_W-1:0] exp_tab_t [EXP_DEPTH];

	function automatic exp_tab_t build_exp_table();
		logic [63:0] acc;
		exp_tab_t    t;
		acc = 64'd1 << 32;
		for (int k = 0; k < EXP_DEPTH; k++) begin
			t[k] = EXP_W'((acc + 64'd32768) >> 16);
			acc  = (acc * EXP_STEP + (64'd1 << 31)) >> 32;
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

// ===== design/dense_layer_forward.sv =====
// A request with op 0, or op 1 without last, is stored while idle; busy stays low.
// An input request with last runs the MAC pass over all neurons and inputs on the
// single shared MAC and drains it, runs the max and exp passes for softmax, then
// reads, loads, divides on the 33-step divider for softmax, and emits each result.
// Results come one per strobe and cannot be stalled by the receiver.
// Asynchronous reset clears control state and returns the registers to defaults.
// ----------------------------------------------------------------------------
// Dense layer forward pass
// Fully connected layer with ReLU or softmax activation in fixed point.
// ----------------------------------------------------------------------------
module dense_layer_forward (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        op,
	input  logic [dlf_pkg::NEU_W-1:0]   row,
	input  logic [dlf_pkg::IN_W-1:0]    col,
	input  logic signed [dlf_pkg::VAL_W-1:0] value,
	input  logic                        last,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [dlf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dlf_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                        strobe,
	output logic [dlf_pkg::NEU_W-1:0]   neuron,
	output logic signed [dlf_pkg::SUM_W-1:0] weighted_sum,
	output logic [dlf_pkg::ACT_W-1:0]   activation,
	output logic                        end_of_run
);
	import dlf_pkg::*;

	dlf_cmd_t    cmd;
	dlf_status_t status;

	dlf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (op),
		.last      (last),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

	dlf_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.row          (row),
		.col          (col),
		.value        (value),
		.strobe       (strobe),
		.neuron       (neuron),
		.weighted_sum (weighted_sum),
		.activation   (activation),
		.end_of_run   (end_of_run)
	);

endmodule

// ===== design/dlf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dlf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/dlf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Dense layer controller
// Holds the configuration registers, sequences the passes and counts neurons.
// ----------------------------------------------------------------------------
module dlf_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           op,
	input  logic                           last,
	output logic                           busy,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dlf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dlf_pkg::CFG_DATA_W-1:0] cfg_data,
	output dlf_pkg::dlf_cmd_t              cmd,
	input  dlf_pkg::dlf_status_t           status
);
	import dlf_pkg::*;

	`include "assert_macros.svh"

	dlf_state_t           state_q, state_d;
	logic                 mode_q;
	logic [NCNT_W-1:0]    ncnt_q, n_eff;
	logic [ICNT_W-1:0]    icnt_q, m_eff;
	logic [NEU_W-1:0]     i_q;
	logic [IN_W-1:0]      j_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 i_last, j_last, div_done;

	assign n_eff = (ncnt_q == '0) ? NCNT_W'(1) :
		(ncnt_q > NCNT_W'(MAX_NEURONS)) ? NCNT_W'(MAX_NEURONS) : ncnt_q;
	assign m_eff = (icnt_q == '0) ? ICNT_W'(1) :
		(icnt_q > ICNT_W'(MAX_INPUTS)) ? ICNT_W'(MAX_INPUTS) : icnt_q;
	assign i_last    = (i_q == NEU_W'(n_eff - NCNT_W'(1)));
	assign j_last    = (j_q == IN_W'(m_eff - ICNT_W'(1)));
	assign div_done  = (div_cnt_q == DIV_CNT_W'(DIV_W - 1));
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			ncnt_q <= NCNT_W'(32);
			icnt_q <= ICNT_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE:    mode_q <= cfg_data[0];
				CFG_NEURONS: ncnt_q <= cfg_data[NCNT_W-1:0];
				CFG_INPUTS:  icnt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && op == OP_INPUT && last) state_d = ST_MAC;
			end
			ST_MAC: begin
				if (i_last && j_last) state_d = ST_MAC_DRAIN;
			end
			ST_MAC_DRAIN: begin
				if (!status.pipe_busy) state_d = mode_q ? ST_MAX : ST_OUT_RD;
			end
			ST_MAX: begin
				if (i_last) state_d = ST_MAX_WAIT;
			end
			ST_MAX_WAIT: state_d = ST_EXP;
			ST_EXP: begin
				if (i_last) state_d = ST_EXP_WAIT;
			end
			ST_EXP_WAIT: state_d = ST_OUT_RD;
			ST_OUT_RD:   state_d = ST_OUT_LOAD;
			ST_OUT_LOAD: state_d = mode_q ? ST_OUT_DIV : ST_EMIT;
			ST_OUT_DIV: begin
				if (div_done) state_d = ST_EMIT;
			end
			ST_EMIT: state_d = i_last ? ST_IDLE : ST_OUT_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.row         = i_q;
		cmd.col         = j_q;
		cmd.softmax     = mode_q;
		cmd.last_neuron = i_last;
		unique case (state_q)
			ST_IDLE: begin
				cmd.w_we = start && (op == OP_WEIGHT);
				cmd.x_we = start && (op == OP_INPUT);
			end
			ST_MAC: begin
				cmd.mac_v     = 1'b1;
				cmd.mac_first = (j_q == '0);
				cmd.mac_last  = j_last;
			end
			ST_MAX: begin
				cmd.max_upd    = 1'b1;
				cmd.pass_first = (i_q == '0);
			end
			ST_EXP: begin
				cmd.exp_acc    = 1'b1;
				cmd.pass_first = (i_q == '0);
			end
			ST_OUT_LOAD: cmd.out_load = 1'b1;
			ST_OUT_DIV:  cmd.div_step = 1'b1;
			ST_EMIT:     cmd.emit     = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			i_q       <= '0;
			j_q       <= '0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					i_q <= '0;
					j_q <= '0;
				end
				ST_MAC: begin
					if (j_last) begin
						j_q <= '0;
						i_q <= i_last ? '0 : i_q + NEU_W'(1);
					end else begin
						j_q <= j_q + IN_W'(1);
					end
				end
				ST_MAX, ST_EXP, ST_EMIT: begin
					i_q <= i_last ? '0 : i_q + NEU_W'(1);
				end
				ST_OUT_LOAD: div_cnt_q <= '0;
				ST_OUT_DIV:  div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
				default: ;
			endcase
		end
	end

	`ASSERT_NEXT(a_last_emit_idle, cmd.emit && cmd.last_neuron, state_q == ST_IDLE,
		"controller did not return to idle after the last result")
	`ASSERT_IMPL(a_div_bounded, state_q == ST_OUT_DIV, div_cnt_q < DIV_CNT_W'(DIV_W),
		"divider step count overran")
	`ASSERT_IMPL(a_no_write_busy, cmd.w_we || cmd.x_we, state_q == ST_IDLE && start,
		"store write outside an accepted request")

endmodule

// ===== design/dlf_datapath.sv =====
// ----------------------------------------------------------------------------
// Dense layer datapath
// Stores, multiply-accumulate pipeline, max and exp passes, divider and
// result registers.
// ----------------------------------------------------------------------------
module dlf_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dlf_pkg::dlf_cmd_t           cmd,
	output dlf_pkg::dlf_status_t        status,
	input  logic [dlf_pkg::NEU_W-1:0]   row,
	input  logic [dlf_pkg::IN_W-1:0]    col,
	input  logic signed [dlf_pkg::VAL_W-1:0] value,
	output logic                        strobe,
	output logic [dlf_pkg::NEU_W-1:0]   neuron,
	output logic signed [dlf_pkg::SUM_W-1:0] weighted_sum,
	output logic [dlf_pkg::ACT_W-1:0]   activation,
	output logic                        end_of_run
);
	import dlf_pkg::*;

	`include "assert_macros.svh"

	logic [VAL_W-1:0]         w_rd, x_rd;
	logic [SUM_W-1:0]         s_rd;
	logic                     mac_v_s1, mac_first_s1, mac_last_s1;
	logic [NEU_W-1:0]         mac_row_s1;
	logic                     mac_v_s2, mac_first_s2, mac_last_s2;
	logic [NEU_W-1:0]         mac_row_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q, acc_sum;
	logic [SUM_W-1:0]         sat_sum;
	logic                     max_s1, exp_s1, first_s1;
	logic [SUM_W-1:0]         max_q, total_q, z_q;
	logic [DIFF_W-1:0]        diff;
	logic [DIFF_W-EXP_IDX_SHIFT-1:0] exp_hi;
	logic [EXP_W-1:0]         e_val;
	logic [SUM_W-1:0]         rem_q;
	logic [DIV_W-1:0]         quo_q;
	logic [DIV_W-1:0]         rem_sh, div_ext;
	logic                     div_ge;
	logic [ACT_W-1:0]         act_d;

	dlf_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NEURONS * MAX_INPUTS)) u_wram (
		.clk   (clk),
		.we    (cmd.w_we),
		.waddr ({row, col}),
		.wdata (value),
		.raddr ({cmd.row, cmd.col}),
		.rdata (w_rd)
	);

	dlf_ram #(.WIDTH(VAL_W), .DEPTH(MAX_INPUTS)) u_xram (
		.clk   (clk),
		.we    (cmd.x_we),
		.waddr (col),
		.wdata (value),
		.raddr (cmd.col),
		.rdata (x_rd)
	);

	dlf_ram #(.WIDTH(SUM_W), .DEPTH(MAX_NEURONS)) u_sram (
		.clk   (clk),
		.we    (mac_v_s2 && mac_last_s2),
		.waddr (mac_row_s2),
		.wdata (sat_sum),
		.raddr (cmd.row),
		.rdata (s_rd)
	);

	assign status.pipe_busy = mac_v_s1 || mac_v_s2;

	assign acc_sum = (mac_first_s2 ? ACC_W'(0) : acc_q) +
		{{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_comb begin
		if (acc_sum[ACC_W-1:SUM_W-1] == '0 || acc_sum[ACC_W-1:SUM_W-1] == '1) begin
			sat_sum = acc_sum[SUM_W-1:0];
		end else if (acc_sum[ACC_W-1]) begin
			sat_sum = {1'b1, {(SUM_W - 1){1'b0}}};
		end else begin
			sat_sum = {1'b0, {(SUM_W - 1){1'b1}}};
		end
	end

	assign diff   = {max_q[SUM_W-1], max_q} - {s_rd[SUM_W-1], s_rd};
	assign exp_hi = diff[DIFF_W-1:EXP_IDX_SHIFT];
	assign e_val  = (exp_hi < (DIFF_W - EXP_IDX_SHIFT)'(EXP_DEPTH)) ?
		EXP_TABLE[exp_hi[EXP_IDX_W-1:0]] : '0;

	assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
	assign div_ext = {1'b0, total_q};
	assign div_ge  = (rem_sh >= div_ext);

	always_comb begin
		if (cmd.softmax) begin
			if (total_q == '0) begin
				act_d = '0;
			end else if (quo_q[DIV_W-1:ACT_W] != '0) begin
				act_d = '1;
			end else begin
				act_d = quo_q[ACT_W-1:0];
			end
		end else if (z_q[SUM_W-1]) begin
			act_d = '0;
		end else if (z_q[SUM_W-2:ACT_W+8] != '0) begin
			act_d = '1;
		end else begin
			act_d = z_q[ACT_W+7:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_v_s1 <= 1'b0;
			mac_v_s2 <= 1'b0;
			max_s1   <= 1'b0;
			exp_s1   <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			mac_v_s1 <= cmd.mac_v;
			mac_v_s2 <= mac_v_s1;
			max_s1   <= cmd.max_upd;
			exp_s1   <= cmd.exp_acc;
			strobe   <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		mac_first_s1 <= cmd.mac_first;
		mac_last_s1  <= cmd.mac_last;
		mac_row_s1   <= cmd.row;
		mac_first_s2 <= mac_first_s1;
		mac_last_s2  <= mac_last_s1;
		mac_row_s2   <= mac_row_s1;
		prod_s2      <= $signed(w_rd) * $signed(x_rd);
		first_s1     <= cmd.pass_first;
		if (mac_v_s2) begin
			acc_q <= acc_sum;
		end
		if (max_s1 && (first_s1 || $signed(s_rd) > $signed(max_q))) begin
			max_q <= s_rd;
		end
		if (exp_s1) begin
			total_q <= (first_s1 ? SUM_W'(0) : total_q) + SUM_W'(e_val);
		end
		if (cmd.out_load) begin
			z_q   <= s_rd;
			rem_q <= '0;
			quo_q <= {e_val, {ACT_W{1'b0}}};
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? SUM_W'(rem_sh - div_ext) : SUM_W'(rem_sh);
			quo_q <= {quo_q[DIV_W-2:0], div_ge};
		end
		if (cmd.emit) begin
			neuron       <= cmd.row;
			weighted_sum <= z_q;
			activation   <= act_d;
			end_of_run   <= cmd.last_neuron;
		end
	end

	`ASSERT_IMPL(a_total_nonzero, cmd.out_load && cmd.softmax, total_q != '0,
		"softmax normalizer is zero at result time")

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Dense layer forward pass testbench
// Drives weight and input requests and register writes, predicts each
// neuron's sum and activation, and compares every strobed result in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dlf_pkg::*;

	typedef struct {
		logic [4:0]         neuron;
		logic signed [31:0] wsum;
		logic [15:0]        act;
		logic               eor;
	} neuron_result_t;

	class dense_scoreboard;
		logic               softmax_mode;
		logic [5:0]         neuron_reg;
		logic [6:0]         input_reg;
		logic signed [15:0] weights [2048];
		logic signed [15:0] inputs [64];
		logic [16:0]        exp_lut [256];
		logic signed [31:0] sums [32];
		logic signed [31:0] peak_sum;
		logic [31:0]        exp_sum;
		neuron_result_t     pending [$];
		int                 mismatches;

		function new();
			logic [63:0] acc;
			acc = 64'd1 << 32;
			for (int k = 0; k < 256; k++) begin
				exp_lut[k] = 17'((acc + 64'd32768) >> 16);
				acc = (acc * 64'd4162825043 + (64'd1 << 31)) >> 32;
			end
			softmax_mode = 0;
			neuron_reg = 32;
			input_reg = 64;
			peak_sum = 0;
			exp_sum = 0;
			mismatches = 0;
			foreach (weights[i]) weights[i] = 0;
			foreach (inputs[i]) inputs[i] = 0;
			foreach (sums[i]) sums[i] = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [6:0] data);
			case (idx)
				CFG_MODE: begin
					softmax_mode = data[0];
				end
				CFG_NEURONS: begin
					neuron_reg = data[5:0];
				end
				CFG_INPUTS: begin
					input_reg = data;
				end
				default: begin
				end
			endcase
		endfunction

		function int neurons_used();
			if (neuron_reg == 0) return 1;
			return neuron_reg > 32 ? 32 : int'(neuron_reg);
		endfunction

		function int inputs_used();
			if (input_reg == 0) return 1;
			return input_reg > 64 ? 64 : int'(input_reg);
		endfunction

		function logic [16:0] exp_of(logic signed [31:0] z);
			longint d;
			d = longint'(peak_sum) - longint'(z);
			if ((d >>> 11) >= 256) return 0;
			return exp_lut[d >>> 11];
		endfunction

		function void note_request(logic op_i, logic [4:0] row_i, logic [5:0] col_i,
				logic signed [15:0] val_i, logic last_i);
			int n;
			int m;
			longint acc;
			longint q;
			neuron_result_t r;
			if (op_i == OP_WEIGHT) begin
				weights[{row_i, col_i}] = val_i;
				return;
			end
			inputs[col_i] = val_i;
			if (!last_i) return;
			n = neurons_used();
			m = inputs_used();
			for (int i = 0; i < n; i++) begin
				acc = 0;
				for (int j = 0; j < m; j++)
					acc += longint'(weights[i * 64 + j]) * longint'(inputs[j]);
				if (acc > 64'sd2147483647) acc = 64'sd2147483647;
				if (acc < -64'sd2147483648) acc = -64'sd2147483648;
				sums[i] = 32'(acc);
			end
			if (softmax_mode) begin
				peak_sum = sums[0];
				for (int i = 1; i < n; i++)
					if (sums[i] > peak_sum) peak_sum = sums[i];
				exp_sum = 0;
				for (int i = 0; i < n; i++) exp_sum += 32'(exp_of(sums[i]));
			end
			for (int i = 0; i < n; i++) begin
				if (softmax_mode)
					q = (exp_sum != 0) ?
						(longint'(exp_of(sums[i])) << 16) / longint'(exp_sum) : 0;
				else
					q = (sums[i] > 0) ? (longint'(sums[i]) >>> 8) : 0;
				if (q > 65535) q = 65535;
				r.neuron = 5'(i);
				r.wsum = sums[i];
				r.act = 16'(q);
				r.eor = (i + 1 == n);
				pending.insert(pending.size(), r);
			end
		endfunction

		function void check_result(neuron_result_t got);
			neuron_result_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: neuron %0d sum %0d act %0d end %0b",
						got.neuron, got.wsum, got.act, got.eor);
				return;
			end
			exp_r = pending.pop_front();
			if (got.neuron !== exp_r.neuron || got.wsum !== exp_r.wsum ||
					got.act !== exp_r.act || got.eor !== exp_r.eor) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"Mismatch: expected neuron %0d sum %0d act %0d end %0b,",
						" got neuron %0d sum %0d act %0d end %0b"},
						exp_r.neuron, exp_r.wsum, exp_r.act, exp_r.eor,
						got.neuron, got.wsum, got.act, got.eor);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               op;
	logic [4:0]         row;
	logic [5:0]         col;
	logic signed [15:0] value;
	logic               last;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [6:0]         cfg_data;
	logic               strobe;
	logic [4:0]         neuron;
	logic signed [31:0] weighted_sum;
	logic [15:0]        activation;
	logic               end_of_run;

	dense_scoreboard sb;
	bit              weight_set [2048];
	bit              input_set [64];
	int              sent_count;
	int              quiet_cycles;
	neuron_result_t  seen;

	dense_layer_forward dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op), .row(row),
		.col(col), .value(value), .last(last), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.strobe(strobe), .neuron(neuron), .weighted_sum(weighted_sum),
		.activation(activation), .end_of_run(end_of_run)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			seen.neuron = neuron;
			seen.wsum = weighted_sum;
			seen.act = activation;
			seen.eor = end_of_run;
			sb.check_result(seen);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 20000) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3: return 16'($urandom_range(0, 511)) - 16'sd256;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send(logic o, logic [4:0] r, logic [5:0] c, logic signed [15:0] v,
			logic l);
		int pct;
		start <= 1'b1;
		op <= o;
		row <= r;
		col <= c;
		value <= v;
		last <= l;
		do @(posedge clk); while (busy);
		sb.note_request(o, r, c, v, l);
		if (o == OP_WEIGHT) weight_set[{r, c}] = 1;
		else input_set[c] = 1;
		sent_count++;
		pct = sent_count < 70 ? 38 : (sent_count < 140 ? 60 : 0);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [6:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(logic mode, logic [6:0] ncnt, logic [6:0] icnt);
		drain();
		write_reg(CFG_MODE, {6'd0, mode});
		write_reg(CFG_NEURONS, ncnt);
		write_reg(CFG_INPUTS, icnt);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_pass();
		int n;
		int m;
		int lc;
		n = sb.neurons_used();
		m = sb.inputs_used();
		for (int i = 0; i < n; i++)
			for (int j = 0; j < m; j++)
				if (!weight_set[i * 64 + j]) send(OP_WEIGHT, 5'(i), 6'(j), pick_value(), 0);
		repeat ($urandom_range(0, 3))
			send(OP_WEIGHT, 5'($urandom_range(0, n - 1)), 6'($urandom_range(0, m - 1)),
				pick_value(), 0);
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 2))
					0: send(OP_WEIGHT, 5'($urandom), 6'($urandom), pick_value(), 0);
					1: send(OP_INPUT, 5'($urandom), 6'($urandom), pick_value(), 0);
					default: send(OP_WEIGHT, 5'($urandom), 6'($urandom), pick_value(), 1);
				endcase
			end
		end
		lc = $urandom_range(0, m - 1);
		for (int j = 0; j < m; j++)
			if (j != lc && (!input_set[j] || $urandom_range(0, 1)))
				send(OP_INPUT, 5'($urandom), 6'(j), pick_value(), 0);
		send(OP_INPUT, 5'($urandom), 6'(lc), pick_value(), 1);
	endtask

	task automatic random_phase(logic mode, logic [6:0] ncnt, logic [6:0] icnt,
			int budget);
		int first;
		configure(mode, ncnt, icnt);
		first = sent_count;
		while (sent_count - first < budget) begin
			run_pass();
			if ($urandom_range(0, 5) == 0) drain();
		end
	endtask

	initial begin
		sb = new();
		sent_count = 0;
		arst_n = 0;
		start = 0;
		op = 0;
		row = 0;
		col = 0;
		value = 0;
		last = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(1'b0, 7'd2, 7'd3);
		for (int j = 0; j < 3; j++) send(OP_WEIGHT, 5'd0, 6'(j), 16'sh8000, 0);
		for (int j = 0; j < 3; j++) send(OP_WEIGHT, 5'd1, 6'(j), 16'sh7FFF, 0);
		send(OP_WEIGHT, 5'd31, 6'd63, 16'sh5555, 1);
		send(OP_INPUT, 5'd31, 6'd0, 16'sh8000, 0);
		send(OP_INPUT, 5'd0, 6'd1, 16'sh8000, 0);
		send(OP_INPUT, 5'd0, 6'd2, 16'sh8000, 1);
		send(OP_INPUT, 5'd0, 6'd63, 16'sh7FFF, 0);
		send(OP_INPUT, 5'd0, 6'd0, 16'sh0100, 0);
		send(OP_INPUT, 5'd0, 6'd1, 16'sh0000, 0);
		send(OP_INPUT, 5'd0, 6'd2, 16'shFFFF, 1);
		configure(1'b1, 7'd2, 7'd3);
		send(OP_INPUT, 5'd0, 6'd2, 16'sh0001, 1);
		send(OP_WEIGHT, 5'd1, 6'd0, 16'sh0100, 0);
		send(OP_INPUT, 5'd0, 6'd0, 16'sh0000, 1);

		random_phase(1'b1, 7'd0, 7'd0, 8);
		random_phase(1'b0, 7'd1, 7'd127, 1);
		random_phase(1'b1, 7'd4, 7'd5, 15);
		random_phase(1'b1, 7'd63, 7'd1, 1);
		random_phase(1'b0, 7'd32, 7'd1, 4);
		random_phase(1'b0, 7'd5, 7'd3, 8);
		random_phase(1'b1, 7'd3, 7'd4, 8);
		drain();
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+design
design/dlf_pkg.sv
design/dlf_ram.sv
design/dlf_ctrl.sv
design/dlf_datapath.sv
design/dense_layer_forward.sv
bench/tb.sv
